// ===== design/scbs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package scbs_pkg;

   localparam int MAX_ORDER = 1024;
   localparam logic [10:0] COUNT_CAP = 11'((MAX_ORDER < 2047) ? MAX_ORDER : 2047);

   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHIFT        = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PIVOT_MIN    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_SUBST   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_COUNT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BRACKET_LOW  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_BRACKET_MID  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_BRACKET_HIGH = 3'd6;

   localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

   // serial units run for one bit of the 32-bit word per cycle
   localparam int RUN_CYCLES = 32;

   typedef struct packed {
      logic signed [31:0] alpha_elem;
      logic [30:0]        beta_sq_elem;
      logic               last_elem;
   } scbs_req_type;

   typedef struct packed {
      logic signed [31:0] new_low;
      logic signed [31:0] new_high;
      logic signed [31:0] new_mid;
      logic [10:0]        eig_count;
   } scbs_rsp_type;

   typedef struct packed {
      logic start;
      logic step;
   } scbs_ctl_type;

endpackage

`default_nettype wire

// ===== design/scbs_serial_sub.sv =====
`timescale 1ns / 1ps
`default_nettype none

module scbs_serial_sub (
   input  logic                   clock,
   input  scbs_pkg::scbs_ctl_type ctl,
   input  logic signed [31:0]     minuend,
   input  logic signed [31:0]     subtrahend,
   output logic signed [32:0]     diff
);

   logic [31:0] a_ff, a_in;
   logic [31:0] s_ff, s_in;
   logic [31:0] r_ff, r_in;
   logic        a_sign_ff, a_sign_in;
   logic        s_sign_ff, s_sign_in;
   logic        carry_ff, carry_in;
   logic        a_bit, b_bit, sum_bit;

   always_comb begin
      a_bit     = a_ff[0];
      b_bit     = ~s_ff[0];
      sum_bit   = a_bit ^ b_bit ^ carry_ff;
      a_in      = a_ff;
      s_in      = s_ff;
      r_in      = r_ff;
      a_sign_in = a_sign_ff;
      s_sign_in = s_sign_ff;
      carry_in  = carry_ff;
      if (ctl.start) begin
         a_in      = minuend;
         s_in      = subtrahend;
         a_sign_in = minuend[31];
         s_sign_in = subtrahend[31];
         carry_in  = 1'b1;
      end else if (ctl.step) begin
         // LSB first: a + ~s + 1, result enters at the top
         a_in     = {1'b0, a_ff[31:1]};
         s_in     = {1'b0, s_ff[31:1]};
         r_in     = {sum_bit, r_ff[31:1]};
         carry_in = (a_bit & b_bit) | (a_bit & carry_ff) | (b_bit & carry_ff);
      end
   end

   always_ff @(posedge clock) begin
      a_ff      <= a_in;
      s_ff      <= s_in;
      r_ff      <= r_in;
      a_sign_ff <= a_sign_in;
      s_sign_ff <= s_sign_in;
      carry_ff  <= carry_in;
   end

   // sign-extended top bit from the final carry
   assign diff = {a_sign_ff ^ ~s_sign_ff ^ carry_ff, r_ff};

endmodule

`default_nettype wire

// ===== design/scbs_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none

module scbs_divider (
   input  logic                   clock,
   input  scbs_pkg::scbs_ctl_type ctl,
   input  logic [30:0]            beta_sq,
   input  logic signed [31:0]     divisor,
   output logic signed [31:0]     quotient
);

   logic [31:0] den_ff, den_in;
   logic [31:0] rem_ff, rem_in;
   logic [30:0] num_ff, num_in;
   logic [30:0] quo_ff, quo_in;
   logic        neg_ff, neg_in;
   logic        zero_ff, zero_in;
   logic        nz_ff, nz_in;
   logic        ovf_ff, ovf_in;
   logic        first_ff, first_in;
   logic [32:0] rem2;
   logic [32:0] rem_diff;
   logic        q_bit;

   always_comb begin
      den_in   = den_ff;
      rem_in   = rem_ff;
      num_in   = num_ff;
      quo_in   = quo_ff;
      neg_in   = neg_ff;
      zero_in  = zero_ff;
      nz_in    = nz_ff;
      ovf_in   = ovf_ff;
      first_in = first_ff;
      rem2     = {rem_ff, num_ff[30]};
      rem_diff = rem2 - {1'b0, den_ff};
      q_bit    = (rem2 >= {1'b0, den_ff});
      if (ctl.start) begin
         den_in   = divisor[31] ? (~divisor + 32'd1) : divisor;
         neg_in   = divisor[31];
         zero_in  = (divisor == 32'sd0);
         nz_in    = (beta_sq != 31'd0);
         // numerator is beta_sq << 16: top 16 bits seed the remainder
         rem_in   = {16'd0, beta_sq[30:15]};
         num_in   = {beta_sq[14:0], 16'd0};
         ovf_in   = 1'b0;
         first_in = 1'b1;
      end else if (ctl.step) begin
         if (first_ff) begin
            // quotient reaches 2^31 exactly when the top part already covers the divisor
            ovf_in   = (rem_ff >= den_ff);
            first_in = 1'b0;
         end else begin
            rem_in = q_bit ? rem_diff[31:0] : rem2[31:0];
            num_in = {num_ff[29:0], 1'b0};
            quo_in = {quo_ff[29:0], q_bit};
         end
      end
   end

   always_ff @(posedge clock) begin
      den_ff   <= den_in;
      rem_ff   <= rem_in;
      num_ff   <= num_in;
      quo_ff   <= quo_in;
      neg_ff   <= neg_in;
      zero_ff  <= zero_in;
      nz_ff    <= nz_in;
      ovf_ff   <= ovf_in;
      first_ff <= first_in;
   end

   always_comb begin
      if (zero_ff) begin
         quotient = nz_ff ? scbs_pkg::Q_MAX : 32'sd0;
      end else if (ovf_ff) begin
         quotient = neg_ff ? scbs_pkg::Q_MIN : scbs_pkg::Q_MAX;
      end else if (neg_ff) begin
         quotient = -$signed({1'b0, quo_ff});
      end else begin
         quotient = $signed({1'b0, quo_ff});
      end
   end

endmodule

`default_nettype wire

// ===== design/sturm_count_bisection_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel  direction  handshake            payload
// req      in         req_valid/req_ready  scbs_req_type (alpha, beta_sq, last)
// rsp      out        rsp_valid/rsp_ready  scbs_rsp_type (low, high, mid, count)
// csr      in         csr_valid/csr_ready  csr_index, csr_data (always ready)
//
// Each element passes through the accept cycle, the run cycles in which the
// bit-serial subtractor and the radix-2 divider advance one bit, and the finish state.
// A synchronous reset clears the pivot, the count and the control and resets the CSRs, but not the result data.
// A last element waits in its finish cycle while the previous result is not taken;
// otherwise a pending result does not hold back the next element.

module sturm_count_bisection_step (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  scbs_pkg::scbs_req_type                req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output scbs_pkg::scbs_rsp_type                rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [scbs_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [31:0]                           csr_data
);

   localparam int CNT_W = $clog2(scbs_pkg::RUN_CYCLES);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(scbs_pkg::RUN_CYCLES - 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               last_ff, last_in;

   logic signed [31:0] pivot_q_ff, pivot_q_in;
   logic [10:0]        neg_count_ff, neg_count_in;
   logic               expect_first_ff, expect_first_in;

   logic signed [31:0] shift_ff, shift_in;
   logic [30:0]        pivot_min_ff, pivot_min_in;
   logic signed [31:0] subst_ff, subst_in;
   logic [10:0]        target_ff, target_in;
   logic signed [31:0] blow_ff, blow_in;
   logic signed [31:0] bmid_ff, bmid_in;
   logic signed [31:0] bhigh_ff, bhigh_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   scbs_pkg::scbs_rsp_type rsp_data_ff, rsp_data_in;

   scbs_pkg::scbs_ctl_type ctl;
   logic signed [32:0]     diff;
   logic signed [31:0]     quo;

   logic signed [31:0] first_sat, first_q;
   logic signed [33:0] later_sum;
   logic signed [31:0] later_sat, neg_pm, later_q;
   logic               later_low;
   logic signed [31:0] q_new;
   logic [10:0]        count_new;
   logic               fin_go;
   logic signed [31:0] lo, hi;
   logic [32:0]        mid_sum;

   scbs_serial_sub u_sub (
      .clock      (clock),
      .ctl        (ctl),
      .minuend    (req_data.alpha_elem),
      .subtrahend (shift_ff),
      .diff       (diff)
   );

   scbs_divider u_div (
      .clock    (clock),
      .ctl      (ctl),
      .beta_sq  (req_data.beta_sq_elem),
      .divisor  (pivot_q_ff),
      .quotient (quo)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      ctl.start = (state_ff == ST_IDLE) && req_valid;
      ctl.step  = (state_ff == ST_RUN);
   end

   // pivot update
   always_comb begin
      if (diff[32] != diff[31]) begin
         first_sat = diff[32] ? scbs_pkg::Q_MIN : scbs_pkg::Q_MAX;
      end else begin
         first_sat = diff[31:0];
      end
      first_q = (diff == 33'sd0) ? subst_ff : first_sat;

      later_sum = {diff[32], diff} - {{2{quo[31]}}, quo};
      if ((later_sum[33] != later_sum[32]) || (later_sum[33] != later_sum[31])) begin
         later_sat = later_sum[33] ? scbs_pkg::Q_MIN : scbs_pkg::Q_MAX;
      end else begin
         later_sat = later_sum[31:0];
      end
      neg_pm    = -$signed({1'b0, pivot_min_ff});
      later_low = (later_sat <= $signed({1'b0, pivot_min_ff}));
      if (later_low && (later_sat > neg_pm)) begin
         later_q = neg_pm;
      end else begin
         later_q = later_sat;
      end

      if (expect_first_ff) begin
         q_new     = first_q;
         count_new = {10'd0, diff[32]};
      end else begin
         q_new     = later_q;
         count_new = neg_count_ff;
         if (later_low && (neg_count_ff < scbs_pkg::COUNT_CAP)) begin
            count_new = neg_count_ff + 11'd1;
         end
      end

      // bisection step
      if (count_new <= target_ff) begin
         lo = bmid_ff;
         hi = bhigh_ff;
      end else begin
         lo = blow_ff;
         hi = bmid_ff;
      end
      mid_sum = {lo[31], lo} + {hi[31], hi};
   end

   always_comb begin
      state_in        = state_ff;
      cnt_in          = cnt_ff;
      last_in         = last_ff;
      pivot_q_in      = pivot_q_ff;
      neg_count_in    = neg_count_ff;
      expect_first_in = expect_first_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_data_in     = rsp_data_ff;
      fin_go          = !(last_ff && rsp_valid_ff && !rsp_ready);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               last_in  = req_data.last_elem;
               cnt_in   = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (fin_go) begin
               state_in = ST_IDLE;
               if (last_ff) begin
                  rsp_valid_in          = 1'b1;
                  rsp_data_in.new_low   = lo;
                  rsp_data_in.new_high  = hi;
                  rsp_data_in.new_mid   = mid_sum[32:1];
                  rsp_data_in.eig_count = count_new;
                  pivot_q_in            = 32'sd0;
                  neg_count_in          = 11'd0;
                  expect_first_in       = 1'b1;
               end else begin
                  pivot_q_in      = q_new;
                  neg_count_in    = count_new;
                  expect_first_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      shift_in     = shift_ff;
      pivot_min_in = pivot_min_ff;
      subst_in     = subst_ff;
      target_in    = target_ff;
      blow_in      = blow_ff;
      bmid_in      = bmid_ff;
      bhigh_in     = bhigh_ff;
      if (csr_valid) begin
         case (csr_index)
            scbs_pkg::CSR_SHIFT:        shift_in     = csr_data;
            scbs_pkg::CSR_PIVOT_MIN:    pivot_min_in = csr_data[30:0];
            scbs_pkg::CSR_ZERO_SUBST:   subst_in     = csr_data;
            scbs_pkg::CSR_TARGET_COUNT: target_in    = csr_data[10:0];
            scbs_pkg::CSR_BRACKET_LOW:  blow_in      = csr_data;
            scbs_pkg::CSR_BRACKET_MID:  bmid_in      = csr_data;
            scbs_pkg::CSR_BRACKET_HIGH: bhigh_in     = csr_data;
            default: begin
               // drop writes to unused indexes
               shift_in = shift_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         cnt_ff          <= '0;
         pivot_q_ff      <= 32'sd0;
         neg_count_ff    <= 11'd0;
         expect_first_ff <= 1'b1;
         rsp_valid_ff    <= 1'b0;
         shift_ff        <= 32'sd0;
         pivot_min_ff    <= 31'd1;
         subst_ff        <= 32'sd0;
         target_ff       <= 11'd0;
         blow_ff         <= 32'sd0;
         bmid_ff         <= 32'sd0;
         bhigh_ff        <= 32'sd0;
      end else begin
         state_ff        <= state_in;
         cnt_ff          <= cnt_in;
         pivot_q_ff      <= pivot_q_in;
         neg_count_ff    <= neg_count_in;
         expect_first_ff <= expect_first_in;
         rsp_valid_ff    <= rsp_valid_in;
         shift_ff        <= shift_in;
         pivot_min_ff    <= pivot_min_in;
         subst_ff        <= subst_in;
         target_ff       <= target_in;
         blow_ff         <= blow_in;
         bmid_ff         <= bmid_in;
         bhigh_ff        <= bhigh_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

// ===== design/scbs_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module scbs_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input scbs_pkg::scbs_rsp_type                rsp_data
);

   logic [32:0] mid_sum;

   assign mid_sum = {rsp_data.new_low[31], rsp_data.new_low}
                  + {rsp_data.new_high[31], rsp_data.new_high};

   // a result stays offered until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped before it was taken");

   // one element at a time: no second accept straight after the first
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted while an element is in work");

   a_mid_avg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.new_mid == mid_sum[32:1]))
      else $error("new_mid is not the floor average of the new bounds");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.eig_count <= scbs_pkg::COUNT_CAP))
      else $error("eig_count above the count limit");

endmodule

bind sturm_count_bisection_step scbs_checker u_scbs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
